// ----- rtl/core/clsrng_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsrng_pkg
// Shared constants and types for the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
package clsrng_pkg;

  localparam int GEN_W  = 31;
  localparam int SEED_W = 32;
  localparam int MUL_W  = 16;
  localparam int PROD_W = GEN_W + MUL_W;
  localparam int FOLD_W = 8;
  localparam int SUM_W  = 32;

  localparam int TABLE_SIZE_DEF = 32;

  // moduli are 2^31 minus a small fold constant
  localparam logic [GEN_W-1:0]  MOD1       = 31'd2147483563;
  localparam logic [GEN_W-1:0]  MOD2       = 31'd2147483399;
  localparam logic [GEN_W-1:0]  MODM1      = 31'd2147483562;
  localparam logic [MUL_W-1:0]  MUL1       = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL2       = 16'd40692;
  localparam logic [FOLD_W-1:0] FOLD1      = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD2      = 8'd249;
  localparam logic [GEN_W-1:0]  GEN2_RESET = 31'd123456789;

  typedef enum logic {
    GEN_SEL_FIRST,
    GEN_SEL_SECOND
  } gen_sel_t;

  typedef struct packed {
    logic     vld;
    gen_sel_t sel;
  } mm_ctl_t;

endpackage

// ----- rtl/core/combined_lcg_shuffle_rng.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Two combined multiplicative LCGs with a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// a draw without reseed goes from idle through draw G1, draw G2, wait and
// capture to output, which registers its beat once the output is free; no
// new draw is taken before idle; in a reseed, which fills the table, each
// generator step waits on the previous through the shared modmul pipeline
// reset: generators, last output, index and table valid bits; no clear pass
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng #(
  parameter int TABLE_SIZE = clsrng_pkg::TABLE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [clsrng_pkg::SEED_W-1:0] in_seed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [clsrng_pkg::GEN_W-1:0]        out_random_value
);
  import clsrng_pkg::*;

  localparam int IDX_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W     = $clog2(TABLE_SIZE + 8);
  localparam logic [63:0] DIVISOR = 64'(MODM1) / 64'(TABLE_SIZE) + 64'd1;
  localparam int DIV_LOG   = $clog2(DIVISOR);
  localparam int IDX_SHIFT = GEN_W + DIV_LOG;
  localparam int RECIP_W   = GEN_W + 2;
  localparam int IPROD_W   = GEN_W + RECIP_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << IDX_SHIFT) + DIVISOR - 64'd1) / DIVISOR;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_INIT_ISS = 4'd1;
  localparam logic [3:0] ST_INIT_W1  = 4'd2;
  localparam logic [3:0] ST_INIT_CAP = 4'd3;
  localparam logic [3:0] ST_DRAW_G1  = 4'd4;
  localparam logic [3:0] ST_DRAW_G2  = 4'd5;
  localparam logic [3:0] ST_DRAW_W   = 4'd6;
  localparam logic [3:0] ST_DRAW_CAP = 4'd7;
  localparam logic [3:0] ST_DRAW_OUT = 4'd8;
  localparam logic [3:0] ST_IDX      = 4'd9;

  localparam logic signed [SEED_W-1:0] SEED_MAX = $signed({1'b0, MODM1});
  localparam logic signed [SEED_W-1:0] SEED_MIN = {1'b1, {(SEED_W-1){1'b0}}};

  logic [3:0]                state_r, state_nxt;
  logic signed [SEED_W-1:0]  first_gen_r, first_gen_nxt;
  logic [GEN_W-1:0]          second_gen_r, second_gen_nxt;
  logic [GEN_W-1:0]          last_output_r, last_output_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      init_r, init_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [GEN_W-1:0]          out_value_r, out_value_nxt;

  logic [GEN_W-1:0]          tab_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0]     tab_vld_r;
  logic [GEN_W-1:0]          tab_rd_r;
  logic                      tab_rd_vld_r;
  logic                      tab_re;
  logic                      tab_we;
  logic [IDX_W-1:0]          tab_waddr;
  logic [GEN_W-1:0]          tab_wdata;
  logic [GEN_W-1:0]          tab_val;

  mm_ctl_t                   mm_req;
  logic [GEN_W-1:0]          mm_z;
  mm_ctl_t                   mm_rsp;
  logic [GEN_W-1:0]          mm_rsp_val;

  logic signed [SEED_W-1:0]  seed_sat;
  logic signed [SEED_W-1:0]  seed_gen;
  logic signed [SEED_W-1:0]  seed_mag;
  logic signed [SUM_W-1:0]   y_diff;
  logic signed [SUM_W-1:0]   y_fix;
  logic [IPROD_W-1:0]        idx_prod;
  logic [IPROD_W-1:0]        idx_full;
  logic                      out_free;

  clsrng_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_ctl (mm_req),
    .req_z   (mm_z),
    .rsp_ctl (mm_rsp),
    .rsp_val (mm_rsp_val)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;
  assign out_free         = !out_valid_r || out_ready;

  // seed decode
  assign seed_sat = (in_seed > SEED_MAX) ? SEED_MAX : in_seed;
  assign seed_gen = (in_seed != '0) ? seed_sat : first_gen_r;
  assign seed_mag = (seed_gen == '0)      ? SEED_W'(1) :
                    (seed_gen == SEED_MIN) ? ~SEED_MIN  : -seed_gen;

  // combine and shuffle
  assign tab_val = tab_rd_vld_r ? tab_rd_r : '0;
  assign y_diff  = $signed({1'b0, tab_val}) - $signed({1'b0, second_gen_r});
  assign y_fix   = (y_diff[SUM_W-1] || (y_diff == '0))
                 ? y_diff + $signed({1'b0, MODM1}) : y_diff;

  // table index by reciprocal multiply
  assign idx_prod = IPROD_W'(last_output_r) * IPROD_W'(RECIP);
  assign idx_full = idx_prod >> IDX_SHIFT;

  always_comb begin
    state_nxt       = state_r;
    first_gen_nxt   = first_gen_r;
    second_gen_nxt  = second_gen_r;
    last_output_nxt = last_output_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    init_nxt        = init_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_value_nxt   = out_value_r;
    mm_req.vld      = 1'b0;
    mm_req.sel      = GEN_SEL_FIRST;
    mm_z            = first_gen_r[GEN_W-1:0];
    tab_re          = 1'b0;
    tab_we          = 1'b0;
    tab_waddr       = idx_r;
    tab_wdata       = first_gen_r[GEN_W-1:0];

    if (mm_rsp.vld) begin
      if (mm_rsp.sel == GEN_SEL_FIRST) begin
        first_gen_nxt = $signed({1'b0, mm_rsp_val});
      end else begin
        second_gen_nxt = mm_rsp_val;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (seed_gen[SEED_W-1] || (seed_gen == '0)) begin
            first_gen_nxt  = seed_mag;
            second_gen_nxt = seed_mag[GEN_W-1:0];
            cnt_nxt        = CNT_W'(TABLE_SIZE + 7);
            init_nxt       = 1'b1;
            state_nxt      = ST_INIT_ISS;
          end else begin
            first_gen_nxt = seed_gen;
            state_nxt     = ST_DRAW_G1;
          end
        end
      end
      ST_INIT_ISS: begin
        mm_req.vld = 1'b1;
        state_nxt  = ST_INIT_W1;
      end
      ST_INIT_W1: begin
        state_nxt = ST_INIT_CAP;
      end
      ST_INIT_CAP: begin
        if (cnt_r < CNT_W'(TABLE_SIZE)) begin
          tab_we    = 1'b1;
          tab_waddr = cnt_r[IDX_W-1:0];
          tab_wdata = mm_rsp_val;
        end
        if (cnt_r == '0) begin
          last_output_nxt = mm_rsp_val;
          state_nxt       = ST_IDX;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_INIT_ISS;
        end
      end
      ST_DRAW_G1: begin
        mm_req.vld = 1'b1;
        tab_re     = 1'b1;
        state_nxt  = ST_DRAW_G2;
      end
      ST_DRAW_G2: begin
        mm_req.vld = 1'b1;
        mm_req.sel = GEN_SEL_SECOND;
        mm_z       = second_gen_r;
        state_nxt  = ST_DRAW_W;
      end
      ST_DRAW_W: begin
        state_nxt = ST_DRAW_CAP;
      end
      ST_DRAW_CAP: begin
        state_nxt = ST_DRAW_OUT;
      end
      ST_DRAW_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_value_nxt   = y_fix[GEN_W-1:0];
          last_output_nxt = y_fix[GEN_W-1:0];
          tab_we          = 1'b1;
          state_nxt       = ST_IDX;
        end
      end
      ST_IDX: begin
        idx_nxt   = (idx_full > IPROD_W'(TABLE_SIZE - 1))
                  ? IDX_W'(TABLE_SIZE - 1) : idx_full[IDX_W-1:0];
        init_nxt  = 1'b0;
        state_nxt = init_r ? ST_DRAW_G1 : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      first_gen_r   <= '1;
      second_gen_r  <= GEN2_RESET;
      last_output_r <= '0;
      idx_r         <= '0;
      cnt_r         <= '0;
      init_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      tab_vld_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      first_gen_r   <= first_gen_nxt;
      second_gen_r  <= second_gen_nxt;
      last_output_r <= last_output_nxt;
      idx_r         <= idx_nxt;
      cnt_r         <= cnt_nxt;
      init_r        <= init_nxt;
      out_valid_r   <= out_valid_nxt;
      if (tab_we) begin
        tab_vld_r[tab_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

  // shuffle table
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rd_r     <= tab_mem[idx_r];
      tab_rd_vld_r <= tab_vld_r[idx_r];
    end
  end

  // checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted beat did not start work");

  a_beat_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_DRAW_OUT)
    else $error("result beat raised outside draw output");

  a_rsp_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.vld |-> (state_r == ST_INIT_CAP || state_r == ST_DRAW_W ||
                    state_r == ST_DRAW_CAP))
    else $error("modmul result arrived in an unexpected state");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_random_value != '0) && (out_random_value <= MODM1))
    else $error("result out of range");

endmodule

// ----- rtl/core/clsrng_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsrng_modmul
// Pipelined modular multiplier shared by both generators: multiply,
// fold the high part by 2^31 mod m, then one conditional subtract.
// ----------------------------------------------------------------------------
module clsrng_modmul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  clsrng_pkg::mm_ctl_t                req_ctl,
  input  logic [clsrng_pkg::GEN_W-1:0]       req_z,
  output clsrng_pkg::mm_ctl_t                rsp_ctl,
  output logic [clsrng_pkg::GEN_W-1:0]       rsp_val
);
  import clsrng_pkg::*;

  mm_ctl_t             mul_ctl_r;
  mm_ctl_t             fold_ctl_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SUM_W-1:0]    sum_r;
  logic [MUL_W-1:0]    mul_k;
  logic [FOLD_W-1:0]   fold_k;
  logic [GEN_W-1:0]    mod_k;
  logic [PROD_W-1:0]   prod_nxt;
  logic [SUM_W-1:0]    sum_nxt;

  assign mul_k  = (req_ctl.sel == GEN_SEL_SECOND) ? MUL2 : MUL1;
  assign fold_k = (mul_ctl_r.sel == GEN_SEL_SECOND) ? FOLD2 : FOLD1;
  assign mod_k  = (fold_ctl_r.sel == GEN_SEL_SECOND) ? MOD2 : MOD1;

  assign prod_nxt = PROD_W'(req_z) * PROD_W'(mul_k);
  assign sum_nxt  = SUM_W'(prod_r[PROD_W-1:GEN_W]) * SUM_W'(fold_k)
                  + SUM_W'(prod_r[GEN_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_ctl_r  <= '0;
      fold_ctl_r <= '0;
    end else begin
      mul_ctl_r  <= req_ctl;
      fold_ctl_r <= mul_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
  end

  assign rsp_ctl = fold_ctl_r;
  assign rsp_val = (sum_r >= SUM_W'(mod_k)) ? GEN_W'(sum_r - SUM_W'(mod_k))
                                            : sum_r[GEN_W-1:0];

endmodule
